FILE: rtl/core/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg: page run allocator shared definitions
// Word types, command codes, status codes and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    localparam int NUM_PAGES_DEF = 256;
    localparam int ROW_SHIFT     = 4;
    localparam int ROW_PAGES     = 2 ** ROW_SHIFT;

    localparam logic [8:0] LIMIT_RESET = 9'd256;

    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_RANGE   = 3'd3,
        ST_DOUBLE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] page_index;
        logic [8:0] run_length;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] run_start;
        logic [8:0] pages_left;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_ALLOC,
        OP_FREE,
        OP_REPLY
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_CHECK,
        S_MARK_RD,
        S_MARK_WR
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    init_wr;
        logic    scan_step;
        logic    check_step;
        logic    mark_rd;
        logic    mark_wr;
        logic    finish;
        t_status status;
    } t_ctl;

    typedef struct packed {
        t_op     op;
        t_status reply;
        logic    row_last;
        logic    scan_hit;
        logic    scan_last;
        logic    check_bad;
        logic    run_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/pra_ctrl.sv
// ----------------------------------------------------------------------------
// pra_ctrl: page run allocator controller
// Sequences init sweep, first-fit scan, double-free check and run marking.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_ctrl
    import pra_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_ctl          o_ctl,
    output logic          o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.accept = 1'b1;
                    case (i_stat.op)
                        OP_INIT:  n_state = S_INIT;
                        OP_ALLOC: n_state = S_SCAN;
                        OP_FREE:  n_state = S_CHECK;
                        default: begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = i_stat.reply;
                        end
                    endcase
                end
            end
            S_INIT: begin
                o_ctl.init_wr = 1'b1;
                if (i_stat.row_last) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_MARK_RD;
                end else if (i_stat.scan_last) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.status = ST_NOSPACE;
                    n_state      = S_IDLE;
                end
            end
            S_CHECK: begin
                o_ctl.check_step = 1'b1;
                if (i_stat.check_bad) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.status = ST_DOUBLE;
                    n_state      = S_IDLE;
                end else if (i_stat.run_last) begin
                    n_state = S_MARK_RD;
                end
            end
            S_MARK_RD: begin
                o_ctl.mark_rd = 1'b1;
                n_state       = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_ctl.mark_wr = 1'b1;
                if (i_stat.run_last) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_MARK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pra_datapath.sv
// ----------------------------------------------------------------------------
// pra_datapath: page run allocator datapath
// Free map memory of sixteen-page rows, row scan logic, free count and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_datapath
    import pra_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire logic i_cfg_we,
    input  wire logic [8:0] i_cfg_wdata,
    input  wire t_ctl i_ctl,
    output t_dp_stat  o_stat,
    output logic      o_strobe,
    output t_rsp      o_rsp
);

    localparam int ROWS = (NUM_PAGES + ROW_PAGES - 1) / ROW_PAGES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW   = (RW + ROW_SHIFT + 1 > 10) ? RW + ROW_SHIFT + 1 : 10;
    localparam int CW   = $clog2(NUM_PAGES + 1);

    logic [ROW_PAGES-1:0] mem [ROWS];
    logic [ROWS-1:0]      r_valid;
    logic [ROW_PAGES-1:0] r_rdata;
    logic                 r_rvalid;

    logic [RW-1:0]        r_row, n_row;
    logic [XW-1:0]        r_lo, r_hi;
    logic [8:0]           r_len;
    logic [1:0]           r_kind;
    logic [ROW_PAGES-1:0] r_lmask;
    logic [XW-1:0]        r_run;
    logic [CW-1:0]        r_count, n_count;
    logic [8:0]           r_limit;

    logic [XW-1:0]        lim, lim_m1, rowbase, len_x, count_x;
    logic [XW-1:0]        req_start, req_len, req_end;
    logic [ROW_PAGES-1:0] rd_eff, lim_mask, run_mask, m;
    logic [ROW_PAGES-1:0] hit;
    logic                 hit_any;
    logic [ROW_SHIFT-1:0] hit_pos;
    logic [XW-1:0]        where, run_out, count_ext;
    logic [RW-1:0]        row_inc, lo_row, hi_row, where_row, lim_row;

    logic                 rd_en, wr_en;
    logic [RW-1:0]        rd_addr;
    logic [ROW_PAGES-1:0] wr_data;

    assign lim       = (XW'(r_limit) > XW'(NUM_PAGES)) ? XW'(NUM_PAGES) : XW'(r_limit);
    assign lim_m1    = lim - XW'(1);
    assign rowbase   = XW'({r_row, {ROW_SHIFT{1'b0}}});
    assign len_x     = XW'(r_len);
    assign count_x   = XW'(r_count);
    assign req_start = XW'(i_req.page_index);
    assign req_len   = XW'(i_req.run_length);
    assign req_end   = req_start + req_len;
    assign rd_eff    = r_rvalid ? r_rdata : '1;
    assign m         = rd_eff & lim_mask;
    assign row_inc   = r_row + RW'(1);
    assign lo_row    = r_lo[RW+ROW_SHIFT-1:ROW_SHIFT];
    assign hi_row    = r_hi[RW+ROW_SHIFT-1:ROW_SHIFT];
    assign where_row = where[RW+ROW_SHIFT-1:ROW_SHIFT];
    assign lim_row   = lim_m1[RW+ROW_SHIFT-1:ROW_SHIFT];

    // decode of the word offered at the command port
    always_comb begin
        o_stat.op        = OP_REPLY;
        o_stat.reply     = ST_OK;
        o_stat.row_last  = (r_row == RW'(ROWS - 1));
        o_stat.scan_hit  = hit_any;
        o_stat.scan_last = (r_row == lim_row);
        o_stat.check_bad = |(rd_eff & run_mask);
        o_stat.run_last  = (r_row == hi_row);
        case (i_req.kind)
            KIND_INIT: begin
                o_stat.op = OP_INIT;
            end
            KIND_ALLOC: begin
                if (i_req.run_length == '0) begin
                    o_stat.reply = ST_ZERO;
                end else if (req_len > count_x || lim == '0) begin
                    o_stat.reply = ST_NOSPACE;
                end else begin
                    o_stat.op = OP_ALLOC;
                end
            end
            KIND_FREE: begin
                if (i_req.run_length == '0) begin
                    o_stat.reply = ST_ZERO;
                end else if (req_end > lim) begin
                    o_stat.reply = ST_RANGE;
                end else begin
                    o_stat.op = OP_FREE;
                end
            end
            default: begin
                o_stat.reply = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < ROW_PAGES; j++) begin
            lim_mask[j] = (rowbase + XW'(j)) < lim;
            run_mask[j] = ((rowbase + XW'(j)) >= r_lo) && ((rowbase + XW'(j)) <= r_hi);
        end
    end

    // first-fit over one row, carrying the free run from the rows below
    always_comb begin : p_scan
        logic [ROW_PAGES-1:0] win;
        logic [ROW_PAGES-1:0] pre;
        pre[0] = m[0];
        for (int j = 1; j < ROW_PAGES; j++) begin
            pre[j] = pre[j-1] & m[j];
        end
        for (int j = 0; j < ROW_PAGES; j++) begin
            win = '0;
            for (int k = 0; k <= j; k++) begin
                win[k] = r_lmask[j-k];
            end
            if (XW'(j + 1) >= len_x) begin
                hit[j] = ((m & win) == win);
            end else begin
                hit[j] = pre[j] && ((r_run + XW'(j + 1)) >= len_x);
            end
        end
        hit_any = 1'b0;
        hit_pos = '0;
        for (int j = ROW_PAGES - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_any = 1'b1;
                hit_pos = ROW_SHIFT'(j);
            end
        end
        run_out = r_run + XW'(ROW_PAGES);
        for (int k = 0; k < ROW_PAGES; k++) begin
            if (!m[k]) begin
                run_out = XW'(ROW_PAGES - 1 - k);
            end
        end
    end

    assign where = rowbase + XW'(hit_pos) + XW'(1) - len_x;

    // memory access and row pointer
    always_comb begin
        n_row   = r_row;
        rd_en   = 1'b0;
        rd_addr = r_row;
        wr_en   = 1'b0;
        wr_data = lim_mask;
        if (i_ctl.accept) begin
            if (o_stat.op == OP_FREE) begin
                n_row   = req_start[RW+ROW_SHIFT-1:ROW_SHIFT];
                rd_en   = 1'b1;
                rd_addr = req_start[RW+ROW_SHIFT-1:ROW_SHIFT];
            end else begin
                n_row   = '0;
                rd_en   = (o_stat.op == OP_ALLOC);
                rd_addr = '0;
            end
        end else if (i_ctl.init_wr) begin
            wr_en   = 1'b1;
            wr_data = lim_mask;
            n_row   = row_inc;
        end else if (i_ctl.scan_step) begin
            if (hit_any) begin
                n_row = where_row;
            end else begin
                n_row   = row_inc;
                rd_en   = !o_stat.scan_last;
                rd_addr = row_inc;
            end
        end else if (i_ctl.check_step) begin
            if (o_stat.run_last) begin
                n_row = lo_row;
            end else begin
                n_row   = row_inc;
                rd_en   = !o_stat.check_bad;
                rd_addr = row_inc;
            end
        end else if (i_ctl.mark_rd) begin
            rd_en = 1'b1;
        end else if (i_ctl.mark_wr) begin
            wr_en   = 1'b1;
            wr_data = (r_kind == KIND_ALLOC) ? (rd_eff & ~run_mask) : (rd_eff | run_mask);
            n_row   = row_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_row] <= wr_data;
        end
        if (rd_en) begin
            r_rdata  <= mem[rd_addr];
            r_rvalid <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_row] <= 1'b1;
        end
    end

    // command word and run registers
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        if (i_ctl.accept) begin
            r_kind <= i_req.kind;
            r_len  <= i_req.run_length;
            r_lo   <= req_start;
            r_hi   <= req_end - XW'(1);
            r_run  <= '0;
            for (int k = 0; k < ROW_PAGES; k++) begin
                r_lmask[k] <= XW'(k) < req_len;
            end
        end else if (i_ctl.scan_step) begin
            if (hit_any) begin
                r_lo <= where;
                r_hi <= where + len_x - XW'(1);
            end else begin
                r_run <= run_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.finish && i_ctl.status == ST_OK) begin
            case (r_kind)
                KIND_INIT:  n_count = CW'(lim);
                KIND_ALLOC: n_count = r_count - CW'(r_len);
                KIND_FREE:  n_count = r_count + CW'(r_len);
                default:    n_count = r_count;
            endcase
        end
    end

    assign count_ext = XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CW'(NUM_PAGES);
            o_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            o_strobe <= i_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            o_rsp.status     <= i_ctl.status;
            o_rsp.run_start  <= (i_ctl.status == ST_OK && r_kind == KIND_ALLOC) ? r_lo[7:0] : '0;
            o_rsp.pages_left <= count_ext[8:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/page_run_allocator_core.sv
// ----------------------------------------------------------------------------
// page_run_allocator_core: first-fit contiguous page run allocator
// Bitmap of free pages with free count; init, allocate and free commands.
// ----------------------------------------------------------------------------
//  channel   | signals                    | handshake
//  ----------+----------------------------+------------------------------------
//  command   | start, busy, i_req         | taken at edge with start && !busy
//  result    | o_strobe, o_rsp            | one-cycle strobe, always taken
//  config    | i_cfg_we, i_cfg_wdata      | written at edge with i_cfg_we
//
//  Rejected words answer in the next cycle. Init writes every sixteen-page row
//  of the map in turn. Allocate scans rows up to the hit, then reads and writes
//  back each row of the run; free checks each row of the run, then reads and
//  writes back each row to mark it.
//  Reset clears per-row valid bits at once: no clearing pass.
//  Results cannot be stalled; busy holds off new commands.
// ----------------------------------------------------------------------------
`default_nettype none

module page_run_allocator_core
    import pra_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_req       i_req,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_wdata,
    output logic            o_strobe,
    output t_rsp            o_rsp
);

    t_ctl     ctl;
    t_dp_stat stat;

    pra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    pra_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pra_checker.sv
// ----------------------------------------------------------------------------
// pra_checker: page run allocator port checks
// Timing of rejected words and result strobes seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_checker
    import pra_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire t_req i_req,
    input wire logic o_strobe,
    input wire t_rsp o_rsp
);

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word while busy");

    a_rsvd_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.kind == KIND_RSVD) |=>
        (o_strobe && o_rsp.status == ST_RANGE))
        else $error("unused kind not answered next cycle");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.kind == KIND_ALLOC || i_req.kind == KIND_FREE)
         && i_req.run_length == '0) |=> (o_strobe && o_rsp.status == ST_ZERO))
        else $error("zero length not answered next cycle");

    a_fail_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ST_OK) |-> (o_rsp.run_start == '0))
        else $error("run start set on failed word");

    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_strobe)
        else $error("result word as busy rises");

endmodule

bind page_run_allocator_core pra_checker u_pra_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);

`default_nettype wire
